// ===== rtl/rei_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event unit package
// Shared widths, codes, command and event types, and the quadrature table.
// ----------------------------------------------------------------------------
package rei_pkg;

   // Field widths.
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned PERIOD_W = 10;
   localparam int unsigned DEB_W    = 4;
   localparam int unsigned SPD_W    = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned PENDING_W = 4;
   localparam int unsigned ACC_W    = 6;

   // Default event queue depth.
   localparam int unsigned QUEUE_DEPTH_DEF = 8;

   // Register reset values.
   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 10'd10;
   localparam logic [DEB_W-1:0]    DEBOUNCE_RST      = 4'd3;
   localparam logic [SPD_W-1:0]    STEPS_RST         = 5'd4;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_PERIOD = 2'd0,
      CSR_DEBOUNCE      = 2'd1,
      CSR_STEPS         = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_idx_type;

   // Command opcodes.
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_AB     = 2'd1,
      OP_POP    = 2'd2,
      OP_INIT   = 2'd3
   } op_type;

   // Event kinds.
   typedef enum logic [1:0] {
      KIND_CW       = 2'd0,
      KIND_CCW      = 2'd1,
      KIND_PRESSED  = 2'd2,
      KIND_RELEASED = 2'd3
   } kind_type;

   // Configuration register set.
   typedef struct packed {
      logic [PERIOD_W-1:0] sample_period_ms;
      logic [DEB_W-1:0]    debounce_samples;
      logic [SPD_W-1:0]    steps_per_detent;
   } cfg_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      op_type            op;
      logic [TIME_W-1:0] time_ms;
      logic              sw_pin;
      logic [1:0]        ab_pins;
   } cmd_type;

   // One queued event.
   typedef struct packed {
      kind_type          kind;
      logic [TIME_W-1:0] time_ms;
      logic              level;
   } event_type;

   // Quadrature step for the previous state in bits 3:2 and the new state in 1:0.
   function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
      logic signed [1:0] step;
      case (idx) inside
         4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
         default:                  step = 2'sd0;
      endcase
      return step;
   endfunction

endpackage

// ===== rtl/rei_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one command word from the source to the sink.
// ----------------------------------------------------------------------------
interface rei_req_if;
   import rei_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [TIME_W-1:0] time_ms;
   logic              sw_pin;
   logic [1:0]        ab_pins;

   modport source (output valid, output opcode, output time_ms, output sw_pin,
                   output ab_pins, input ready);
   modport sink   (input valid, input opcode, input time_ms, input sw_pin,
                   input ab_pins, output ready);
endinterface

// ===== rtl/rei_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one result word from the source to the sink.
// ----------------------------------------------------------------------------
interface rei_rsp_if;
   import rei_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 event_valid;
   logic [1:0]           event_kind;
   logic [TIME_W-1:0]    event_time_ms;
   logic                 event_sw_level;
   logic [PENDING_W-1:0] pending_count;

   modport source (output valid, output event_valid, output event_kind,
                   output event_time_ms, output event_sw_level,
                   output pending_count, input ready);
   modport sink   (input valid, input event_valid, input event_kind,
                   input event_time_ms, input event_sw_level,
                   input pending_count, output ready);
endinterface

// ===== rtl/rei_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event unit front
// Accepts request words, classifies the opcode and holds the commands in a
// two-entry queue for the back.
// ----------------------------------------------------------------------------
module rei_front (
   input  logic              clock,
   input  logic              reset,
   rei_req_if.sink           req_chan,
   output rei_pkg::cmd_type  q_cmd,
   output logic              q_valid,
   input  logic              q_ready
);
   import rei_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   cmd_type    cmd_new;

   // Classify the incoming word.
   always_comb begin
      cmd_new.op      = op_type'(req_chan.opcode);
      cmd_new.time_ms = req_chan.time_ms;
      cmd_new.sw_pin  = req_chan.sw_pin;
      cmd_new.ab_pins = req_chan.ab_pins;
   end

   assign req_chan.ready = (fill_ff != 2'd2);
   assign q_valid        = (fill_ff != 2'd0);
   assign q_cmd          = entry_ff[rd_ptr_ff];
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = q_valid && q_ready;

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== rtl/rei_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event unit back
// Executes one command per cycle while the response register is free: switch
// debounce, quadrature decode, event queue, and the registered response word.
// ----------------------------------------------------------------------------
module rei_back #(
   parameter int unsigned QUEUE_DEPTH = rei_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rei_pkg::cfg_type  cfg,
   input  rei_pkg::cmd_type  q_cmd,
   input  logic              q_valid,
   output logic              q_ready,
   rei_rsp_if.source         rsp_chan
);
   import rei_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   // Debounce and decoder state.
   logic              stable_ff, stable_in;
   logic              cand_ff, cand_in;
   logic [DEB_W-1:0]  cand_cnt_ff, cand_cnt_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [1:0]        last_ab_ff, last_ab_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   // Event queue state.
   event_type         mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ev_valid_ff;
   event_type         ev_data_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              fire;
   logic              push_req, push, pop_ok;
   event_type         push_entry;
   logic [TIME_W-1:0] elapsed;
   logic              sample_ok;
   logic [DEB_W-1:0]  cnt_sat;
   logic signed [1:0] delta;
   logic signed [ACC_W:0] acc_sum;
   logic signed [ACC_W:0] lim;

   assign fire    = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign q_ready = !rsp_valid_ff || rsp_chan.ready;

   // Command execution.
   always_comb begin
      stable_in    = stable_ff;
      cand_in      = cand_ff;
      cand_cnt_in  = cand_cnt_ff;
      last_time_in = last_time_ff;
      last_ab_in   = last_ab_ff;
      acc_in       = acc_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      push_req     = 1'b0;
      pop_ok       = 1'b0;
      push_entry.kind    = KIND_CW;
      push_entry.time_ms = q_cmd.time_ms;
      push_entry.level   = stable_ff;

      elapsed   = q_cmd.time_ms - last_time_ff;
      sample_ok = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.sample_period_ms});
      cnt_sat   = (cand_cnt_ff < cfg.debounce_samples) ? cand_cnt_ff + 1'b1 : cand_cnt_ff;
      delta     = quad_step({last_ab_ff, q_cmd.ab_pins});
      acc_sum   = $signed({acc_ff[ACC_W-1], acc_ff})
                  + $signed({{(ACC_W-1){delta[1]}}, delta});
      lim       = $signed({{(ACC_W+1-SPD_W){1'b0}}, cfg.steps_per_detent});

      if (fire) begin
         unique case (q_cmd.op)
            OP_SAMPLE: begin
               if (sample_ok) begin
                  last_time_in = q_cmd.time_ms;
                  if (q_cmd.sw_pin != cand_ff) begin
                     cand_in     = q_cmd.sw_pin;
                     cand_cnt_in = DEB_W'(1);
                  end else begin
                     cand_cnt_in = cnt_sat;
                     if (cnt_sat >= cfg.debounce_samples && stable_ff != cand_ff) begin
                        stable_in          = cand_ff;
                        push_req           = 1'b1;
                        push_entry.kind    = cand_ff ? KIND_RELEASED : KIND_PRESSED;
                        push_entry.level   = cand_ff;
                     end
                  end
               end
            end
            OP_AB: begin
               last_ab_in = q_cmd.ab_pins;
               if (delta != 2'sd0) begin
                  if (acc_sum >= lim) begin
                     acc_in          = '0;
                     push_req        = 1'b1;
                     push_entry.kind = KIND_CW;
                  end else if (acc_sum <= -lim) begin
                     acc_in          = '0;
                     push_req        = 1'b1;
                     push_entry.kind = KIND_CCW;
                  end else begin
                     acc_in = acc_sum[ACC_W-1:0];
                  end
               end
            end
            OP_POP: begin
               if (count_ff != '0) begin
                  pop_ok    = 1'b1;
                  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            OP_INIT: begin
               stable_in    = q_cmd.sw_pin;
               cand_in      = q_cmd.sw_pin;
               cand_cnt_in  = '0;
               last_time_in = q_cmd.time_ms;
               last_ab_in   = q_cmd.ab_pins;
               acc_in       = '0;
               wr_ptr_in    = '0;
               rd_ptr_in    = '0;
               count_in     = '0;
            end
            default: begin
               last_ab_in = last_ab_ff;
            end
         endcase
      end

      // A new event is dropped when the queue is full.
      push = push_req && (count_ff < CNT_FULL);
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
   end

   // Response valid is set on each executed command and cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= 1'b1;
         cand_ff      <= 1'b1;
         cand_cnt_ff  <= '0;
         last_time_ff <= '0;
         last_ab_ff   <= 2'b00;
         acc_ff       <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stable_ff    <= stable_in;
         cand_ff      <= cand_in;
         cand_cnt_ff  <= cand_cnt_in;
         last_time_ff <= last_time_in;
         last_ab_ff   <= last_ab_in;
         acc_ff       <= acc_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Event memory with the read data registered straight into the response.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
      if (pop_ok) begin
         ev_data_ff <= mem[rd_ptr_ff];
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         ev_valid_ff  <= pop_ok;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.event_valid    = ev_valid_ff;
   assign rsp_chan.event_kind     = ev_valid_ff ? ev_data_ff.kind : KIND_CW;
   assign rsp_chan.event_time_ms  = ev_valid_ff ? ev_data_ff.time_ms : '0;
   assign rsp_chan.event_sw_level = ev_valid_ff ? ev_data_ff.level : 1'b0;
   assign rsp_chan.pending_count  = PENDING_W'(rsp_count_ff);

   // The queue never holds more events than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("event count exceeds queue depth");

   // A successful pop removes exactly one event.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (fire && q_cmd.op == OP_POP && count_ff != '0)
      |=> (count_ff == $past(count_ff) - 1'b1) && ev_valid_ff)
      else $error("pop did not remove one event");

   // Init empties the queue and clears the accumulator.
   a_init_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && q_cmd.op == OP_INIT)
      |=> (count_ff == '0) && (acc_ff == '0) && !ev_valid_ff)
      else $error("init did not clear state");

endmodule

// ===== rtl/rotary_encoder_event_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event unit core
// Quadrature decoder with debounced push switch and a timestamped event queue.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command word: switch sample, A/B pin change, pop or
//   init, with the current millisecond time and the pin levels.
//   rsp_chan returns exactly one result word per command, in order. A pop
//   that finds an event returns it with event_valid set; every other word
//   reports only pending_count.
//   The csr_ port writes one of sample period, debounce count and steps per
//   detent at a time; write them only while no command is in flight.
// Pipeline and throughput:
//   An accepted command is held in the front queue register and is then
//   executed into the result register. One command is taken every cycle
//   while rsp_chan does not stall; the execution stage updates all state
//   as it executes each command.
// Reset and stall:
//   Reset restores the register defaults, releases the switch and empties
//   the queue. When rsp_chan stalls, the result register holds and the
//   two-entry front queue absorbs commands until it fills, then drops ready.
// ----------------------------------------------------------------------------
module rotary_encoder_event_unit_core #(
   parameter int unsigned QUEUE_DEPTH = rei_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   rei_req_if.sink                           req_chan,
   rei_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [rei_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rei_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rei_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type q_cmd;
   logic    q_valid;
   logic    q_ready;

   // Configuration register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SAMPLE_PERIOD: cfg_in.sample_period_ms = csr_wdata[PERIOD_W-1:0];
            CSR_DEBOUNCE:      cfg_in.debounce_samples = csr_wdata[DEB_W-1:0];
            CSR_STEPS:         cfg_in.steps_per_detent = csr_wdata[SPD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period_ms <= SAMPLE_PERIOD_RST;
         cfg_ff.debounce_samples <= DEBOUNCE_RST;
         cfg_ff.steps_per_detent <= STEPS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rei_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_cmd    (q_cmd),
      .q_valid  (q_valid),
      .q_ready  (q_ready)
   );

   rei_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_cmd    (q_cmd),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sim/tb_rotary_encoder_event_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder event unit core testbench
// Drives command words into the core, mirrors the debounce, quadrature and
// event queue behavior in a local model, and checks every result word in
// order. A short scripted table comes first, then randomized traffic in
// several register settings, most with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_event_unit_core;
   import rei_pkg::*;

   localparam int QDEPTH        = QUEUE_DEPTH_DEF;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_PCT      = 21;

   // One result word as seen on the response channel.
   typedef struct packed {
      logic                 ev_valid;
      logic [1:0]           kind;
      logic [TIME_W-1:0]    stamp;
      logic                 level;
      logic [PENDING_W-1:0] pending;
   } rsp_word_type;

   // One line of the scripted table: either a register setting or a command.
   typedef struct {
      logic                 load_cfg;
      logic [PERIOD_W-1:0]  period;
      logic [DEB_W-1:0]     debounce;
      logic [SPD_W-1:0]     steps;
      op_type               op;
      logic [TIME_W-1:0]    stamp;
      logic                 sw;
      logic [1:0]           ab;
      logic                 typed;
      logic [PENDING_W-1:0] fixed_pending;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rei_req_if req_if ();
   rei_rsp_if rsp_if ();

   rotary_encoder_event_unit_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Result words owed by the core, oldest first.
   rsp_word_type   due_results [$];
   script_row_type script_rows [$];
   int             fail_count   = 0;
   int             quiet_cycles = 0;
   bit             idle_on      = 1'b1;

   // Local copy of the registers and the encoder state.
   logic [PERIOD_W-1:0] cfg_period;
   logic [DEB_W-1:0]    cfg_debounce;
   logic [SPD_W-1:0]    cfg_steps;
   logic                st_level;
   logic                cand_level;
   int                  cand_count;
   logic [TIME_W-1:0]   last_sample;
   logic [1:0]          last_pins;
   int                  step_acc;
   event_type           ev_mem [QDEPTH];
   int                  rd_ptr;
   int                  wr_ptr;
   int                  ev_count;

   // Random stimulus state: running time, true switch level, pin levels.
   logic [TIME_W-1:0] cur_time;
   logic              true_level;
   logic [1:0]        stim_pins;
   logic              turn_cw;

   // Step of the quadrature decoder for previous and new A/B levels.
   function automatic int quad_delta(input logic [1:0] prev, input logic [1:0] next);
      int d;
      case ({prev, next})
         4'b0010, 4'b0100, 4'b1011, 4'b1101: d = 1;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: d = -1;
         default:                            d = 0;
      endcase
      return d;
   endfunction

   // Next A/B levels for one clean step in the given direction.
   function automatic logic [1:0] next_pins(input logic [1:0] cur, input logic cw);
      logic [1:0] n;
      case (cur)
         2'd0:    n = cw ? 2'd2 : 2'd1;
         2'd1:    n = cw ? 2'd0 : 2'd3;
         2'd2:    n = cw ? 2'd3 : 2'd0;
         default: n = cw ? 2'd1 : 2'd2;
      endcase
      return n;
   endfunction

   function automatic void push_event(input kind_type kind, input logic [TIME_W-1:0] stamp,
                                      input logic level);
      if (ev_count < QDEPTH) begin
         ev_mem[wr_ptr].kind    = kind;
         ev_mem[wr_ptr].time_ms = stamp;
         ev_mem[wr_ptr].level   = level;
         wr_ptr   = (wr_ptr + 1) % QDEPTH;
         ev_count = ev_count + 1;
      end
   endfunction

   // Applies one command to the local state and returns the word it yields.
   function automatic rsp_word_type encoder_step(input op_type op,
                                                 input logic [TIME_W-1:0] t,
                                                 input logic sw, input logic [1:0] ab);
      rsp_word_type      w;
      logic [TIME_W-1:0] elapsed;
      int                d;
      w = '0;
      case (op)
         OP_SAMPLE: begin
            elapsed = t - last_sample;
            if (elapsed >= TIME_W'(cfg_period)) begin
               last_sample = t;
               if (sw != cand_level) begin
                  cand_level = sw;
                  cand_count = 1;
               end else begin
                  if (cand_count < int'(cfg_debounce))
                     cand_count = cand_count + 1;
                  if (cand_count >= int'(cfg_debounce) && st_level != cand_level) begin
                     st_level = cand_level;
                     push_event(st_level ? KIND_RELEASED : KIND_PRESSED, t, st_level);
                  end
               end
            end
         end
         OP_AB: begin
            d = quad_delta(last_pins, ab);
            last_pins = ab;
            if (d != 0) begin
               step_acc = step_acc + d;
               if (step_acc >= int'(cfg_steps)) begin
                  step_acc = 0;
                  push_event(KIND_CW, t, st_level);
               end else if (step_acc <= -int'(cfg_steps)) begin
                  step_acc = 0;
                  push_event(KIND_CCW, t, st_level);
               end
            end
         end
         OP_POP: begin
            if (ev_count != 0) begin
               w.ev_valid = 1'b1;
               w.kind     = ev_mem[rd_ptr].kind;
               w.stamp    = ev_mem[rd_ptr].time_ms;
               w.level    = ev_mem[rd_ptr].level;
               rd_ptr     = (rd_ptr + 1) % QDEPTH;
               ev_count   = ev_count - 1;
            end
         end
         default: begin
            st_level    = sw;
            cand_level  = sw;
            cand_count  = 0;
            last_sample = t;
            last_pins   = ab;
            step_acc    = 0;
            rd_ptr      = 0;
            wr_ptr      = 0;
            ev_count    = 0;
         end
      endcase
      w.pending = PENDING_W'(ev_count);
      return w;
   endfunction

   task automatic add_row(input op_type op, input logic [TIME_W-1:0] stamp, input logic sw,
                          input logic [1:0] ab, input logic typed,
                          input logic [PENDING_W-1:0] fixed_pending);
      script_row_type r;
      r = '{load_cfg: 1'b0, period: '0, debounce: '0, steps: '0, op: op, stamp: stamp,
            sw: sw, ab: ab, typed: typed, fixed_pending: fixed_pending};
      script_rows.push_back(r);
   endtask

   task automatic add_cfg(input logic [PERIOD_W-1:0] p, input logic [DEB_W-1:0] d,
                          input logic [SPD_W-1:0] s);
      script_row_type r;
      r = '{load_cfg: 1'b1, period: p, debounce: d, steps: s, op: OP_POP, stamp: '0,
            sw: 1'b0, ab: 2'd0, typed: 1'b0, fixed_pending: '0};
      script_rows.push_back(r);
   endtask

   // Offers one command word and waits until the core takes it.
   task automatic send_word(input op_type op, input logic [TIME_W-1:0] t, input logic sw,
                            input logic [1:0] ab, input logic typed,
                            input logic [PENDING_W-1:0] fixed_pending);
      rsp_word_type w;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.opcode  <= op;
      req_if.time_ms <= t;
      req_if.sw_pin  <= sw;
      req_if.ab_pins <= ab;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      w = encoder_step(op, t, sw, ab);
      if (typed) begin
         w = '0;
         w.pending = fixed_pending;
      end
      due_results.push_back(w);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Waits for the core to drain, then loads all three registers.
   task automatic apply_settings(input logic [PERIOD_W-1:0] p, input logic [DEB_W-1:0] d,
                                 input logic [SPD_W-1:0] s);
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      write_csr(CSR_SAMPLE_PERIOD, CSR_DATA_W'(p));
      write_csr(CSR_DEBOUNCE, CSR_DATA_W'(d));
      write_csr(CSR_STEPS, CSR_DATA_W'(s));
      csr_we       <= 1'b0;
      cfg_period   = p;
      cfg_debounce = d;
      cfg_steps    = s;
   endtask

   // Random traffic: mostly clean rotation and slowly changing switch levels.
   task automatic run_phase(input int n_words, input int pop_pct);
      int                r;
      op_type            op;
      logic              sw;
      logic [1:0]        ab;
      logic [TIME_W-1:0] dt;
      for (int i = 0; i < n_words; i++) begin
         r  = $urandom_range(99);
         sw = 1'($urandom_range(1));
         ab = 2'($urandom_range(3));
         if (r < 2) begin
            op         = OP_INIT;
            cur_time   = $urandom;
            true_level = sw;
            stim_pins  = ab;
            step_acc   = step_acc;
         end else if (r < 2 + pop_pct) begin
            op = OP_POP;
         end else if ($urandom_range(99) < 45) begin
            op = OP_SAMPLE;
            if ($urandom_range(99) < 4)
               true_level = ~true_level;
            sw = ($urandom_range(99) < 10) ? ~true_level : true_level;
            r  = $urandom_range(99);
            if (r < 65)
               dt = TIME_W'(cfg_period) + $urandom_range(cfg_period / 2 + 1);
            else if (r < 85)
               dt = $urandom_range(cfg_period);
            else if (r < 95)
               dt = $urandom_range(3);
            else
               dt = $urandom;
            cur_time = cur_time + dt;
         end else begin
            op = OP_AB;
            if ($urandom_range(99) < 5)
               turn_cw = ~turn_cw;
            r = $urandom_range(99);
            if (r < 85)
               ab = next_pins(stim_pins, turn_cw);
            else if (r < 92)
               ab = stim_pins;
            stim_pins = ab;
            cur_time  = cur_time + $urandom_range(5);
         end
         send_word(op, cur_time, sw, ab, 1'b0, '0);
      end
   endtask

   // Response side backpressure.
   always @(posedge clock) begin
      rsp_if.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
   end

   // Compare each result word against the oldest one owed.
   always @(posedge clock) begin : check_results
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.ev_valid = rsp_if.event_valid;
         got.kind     = rsp_if.event_kind;
         got.stamp    = rsp_if.event_time_ms;
         got.level    = rsp_if.event_sw_level;
         got.pending  = rsp_if.pending_count;
         if (due_results.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
               $display("%0t: result word with none outstanding: v=%0d k=%0d t=%h l=%0d n=%0d",
                        $realtime, got.ev_valid, got.kind, got.stamp, got.level, got.pending);
         end else begin
            want = due_results.pop_front();
            if (got.ev_valid !== want.ev_valid || got.kind !== want.kind ||
                got.stamp !== want.stamp || got.level !== want.level ||
                got.pending !== want.pending) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $write("%0t: mismatch: expected v=%0d k=%0d t=%h l=%0d n=%0d,",
                         $realtime, want.ev_valid, want.kind, want.stamp, want.level,
                         want.pending);
                  $display(" got v=%0d k=%0d t=%h l=%0d n=%0d",
                           got.ev_valid, got.kind, got.stamp, got.level, got.pending);
               end
            end
         end
      end
   end

   // Watchdog on cycles where neither channel moves a word.
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.opcode  <= OP_POP;
      req_if.time_ms <= '0;
      req_if.sw_pin  <= 1'b0;
      req_if.ab_pins <= 2'd0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_SAMPLE_PERIOD;
      csr_wdata      <= '0;

      // Model state after reset.
      cfg_period   = SAMPLE_PERIOD_RST;
      cfg_debounce = DEBOUNCE_RST;
      cfg_steps    = STEPS_RST;
      st_level     = 1'b1;
      cand_level   = 1'b1;
      cand_count   = 0;
      last_sample  = '0;
      last_pins    = 2'd0;
      step_acc     = 0;
      rd_ptr       = 0;
      wr_ptr       = 0;
      ev_count     = 0;

      // Reset values: pop on empty queue, then init near the top of the time range.
      add_row(OP_POP,    32'h0000_0000, 1'b0, 2'd0, 1'b1, 4'd0);
      add_row(OP_INIT,   32'hFFFF_FFF0, 1'b1, 2'd0, 1'b1, 4'd0);
      // Press: one early sample is rejected, then three samples across the wrap.
      add_row(OP_SAMPLE, 32'hFFFF_FFF5, 1'b0, 2'd3, 1'b0, 4'd0);
      add_row(OP_SAMPLE, 32'hFFFF_FFFA, 1'b0, 2'd0, 1'b0, 4'd0);
      add_row(OP_SAMPLE, 32'h0000_0004, 1'b0, 2'd0, 1'b0, 4'd0);
      add_row(OP_SAMPLE, 32'h0000_000E, 1'b0, 2'd0, 1'b0, 4'd0);
      // One clockwise detent, an invalid jump, then one counter-clockwise detent.
      add_row(OP_AB,     32'h0000_0020, 1'b1, 2'd2, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0021, 1'b1, 2'd3, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0022, 1'b1, 2'd1, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0023, 1'b1, 2'd0, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0024, 1'b0, 2'd3, 1'b0, 4'd0);
      add_row(OP_AB,     32'hFFFF_FFFC, 1'b0, 2'd2, 1'b0, 4'd0);
      add_row(OP_AB,     32'hFFFF_FFFD, 1'b0, 2'd0, 1'b0, 4'd0);
      add_row(OP_AB,     32'hFFFF_FFFE, 1'b0, 2'd1, 1'b0, 4'd0);
      add_row(OP_AB,     32'hFFFF_FFFF, 1'b1, 2'd3, 1'b0, 4'd0);
      // Zero period, zero debounce and zero steps; the queue fills and drops one.
      add_cfg(10'd0, 4'd0, 5'd0);
      add_row(OP_SAMPLE, 32'h0000_0100, 1'b1, 2'd0, 1'b0, 4'd0);
      add_row(OP_SAMPLE, 32'h0000_0100, 1'b1, 2'd0, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0200, 1'b0, 2'd1, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0201, 1'b0, 2'd0, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0202, 1'b1, 2'd2, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0203, 1'b1, 2'd3, 1'b0, 4'd0);
      add_row(OP_AB,     32'h0000_0204, 1'b1, 2'd1, 1'b0, 4'd0);
      add_row(OP_POP,    32'hFFFF_FFFF, 1'b1, 2'd3, 1'b0, 4'd0);
      add_row(OP_POP,    32'h0000_0000, 1'b0, 2'd0, 1'b0, 4'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i]) begin
         if (script_rows[i].load_cfg)
            apply_settings(script_rows[i].period, script_rows[i].debounce,
                           script_rows[i].steps);
         else
            send_word(script_rows[i].op, script_rows[i].stamp, script_rows[i].sw,
                      script_rows[i].ab, script_rows[i].typed, script_rows[i].fixed_pending);
      end

      // Randomized traffic under a series of register settings.
      cur_time   = 32'h0000_0204;
      true_level = 1'b1;
      stim_pins  = 2'd1;
      turn_cw    = 1'b1;
      apply_settings(10'd10, 4'd3, 5'd4);
      run_phase(120, 25);
      apply_settings(10'd0, 4'd0, 5'd0);
      run_phase(120, 40);
      // A long stretch without idle cycles on either side.
      idle_on = 1'b0;
      apply_settings(10'd1023, 4'd15, 5'd31);
      run_phase(100, 15);
      apply_settings(10'd1, 4'd1, 5'd1);
      run_phase(100, 10);
      idle_on = 1'b1;
      apply_settings(PERIOD_W'($urandom_range(1000, 1)), DEB_W'($urandom_range(15, 1)),
                     SPD_W'($urandom_range(16, 1)));
      run_phase(120, 30);
      apply_settings(10'd512, 4'd8, 5'd16);
      run_phase(120, 5);
      apply_settings(PERIOD_W'($urandom), DEB_W'($urandom), SPD_W'($urandom));
      run_phase(120, 30);

      // Drain and finish.
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== rotary_encoder_event_unit_core.f =====
rtl/rei_pkg.sv
rtl/rei_req_if.sv
rtl/rei_rsp_if.sv
rtl/rei_front.sv
rtl/rei_back.sv
rtl/rotary_encoder_event_unit_core.sv
sim/tb_rotary_encoder_event_unit_core.sv
